// File: hdl/lswg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lswg_pkg;

	// shape codes as they arrive on cmd
	typedef enum logic [1:0] {
		CMD_CIRCLE = 2'd0,
		CMD_SQUARE = 2'd1,
		CMD_CROSS  = 2'd2,
		CMD_POINT  = 2'd3
	} cmd_t;

	// final scaling applied to a point's numerator
	typedef enum logic [1:0] {
		DIV_NONE  = 2'd0,
		DIV_SHIFT = 2'd1,
		DIV_SIX   = 2'd2,
		DIV_22    = 2'd3
	} div_mode_t;

	localparam int unsigned CIRCLE_POINTS = 20;
	localparam int unsigned EDGE_POINTS   = 6;
	localparam int unsigned DIAG_POINTS   = 12;
	localparam int unsigned SHAPE_POINTS  = 24;

	localparam int unsigned IDX_W        = 5;
	localparam int unsigned STEP_W       = 4;
	localparam int unsigned GRP_W        = 2;
	localparam int unsigned TRIG_W       = 18;
	localparam int unsigned CIRCLE_SHIFT = 17;

	// one point request from the sequencer
	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [IDX_W-1:0]  idx;
		logic [STEP_W-1:0] step;
		logic [GRP_W-1:0]  grp;
		logic              last;
	} issue_t;

	// cos(2*pi*i/20) in Q1.16
	function automatic logic signed [TRIG_W-1:0] cos_q16(input logic [IDX_W-1:0] i);
		logic signed [TRIG_W-1:0] v;
		case (i)
			5'd0:    v = 18'sd65536;
			5'd1:    v = 18'sd62328;
			5'd2:    v = 18'sd53020;
			5'd3:    v = 18'sd38521;
			5'd4:    v = 18'sd20252;
			5'd5:    v = 18'sd0;
			5'd6:    v = -18'sd20252;
			5'd7:    v = -18'sd38521;
			5'd8:    v = -18'sd53020;
			5'd9:    v = -18'sd62328;
			5'd10:   v = -18'sd65536;
			5'd11:   v = -18'sd62328;
			5'd12:   v = -18'sd53020;
			5'd13:   v = -18'sd38521;
			5'd14:   v = -18'sd20252;
			5'd15:   v = 18'sd0;
			5'd16:   v = 18'sd20252;
			5'd17:   v = 18'sd38521;
			5'd18:   v = 18'sd53020;
			5'd19:   v = 18'sd62328;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

	// sin(k) = cos((k + 15) mod 20)
	function automatic logic signed [TRIG_W-1:0] sin_q16(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] j;
		j = (i >= 5'd5) ? (i - 5'd5) : (i + 5'd15);
		return cos_q16(j);
	endfunction

endpackage

`default_nettype wire

// File: hdl/lswg_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lswg_seq import lswg_pkg::*; #(
	parameter int unsigned DAC_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          cmd,
	input  wire logic [DAC_BITS-1:0] center_x,
	input  wire logic [DAC_BITS-1:0] center_y,
	input  wire logic [DAC_BITS-1:0] size,
	output logic                     busy,
	output issue_t                   issue,
	output logic [DAC_BITS-1:0]      cx,
	output logic [DAC_BITS-1:0]      cy,
	output logic [DAC_BITS-1:0]      sz,
	output logic [DAC_BITS-1:0]      x_lo,
	output logic [DAC_BITS-1:0]      x_hi,
	output logic [DAC_BITS-1:0]      y_lo,
	output logic [DAC_BITS-1:0]      y_hi
);

	localparam logic [DAC_BITS-1:0] DAC_MAX = '1;

	logic              active_q;
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	logic [GRP_W-1:0]  grp_q;

	logic [DAC_BITS-1:0] cx_q, cy_q, sz_q;
	logic [DAC_BITS-1:0] xl_q, xh_q, yl_q, yh_q;

	logic [IDX_W-1:0]    last_idx;
	logic [STEP_W-1:0]   step_top;
	logic                is_last;
	logic                take;
	logic [2*DAC_BITS-1:0] x_corner, y_corner;

	// square corners {hi, lo}: floor(max(0, c - s/2)), min(max, floor(c + s/2))
	function automatic logic [2*DAC_BITS-1:0] corners(
		input logic [DAC_BITS-1:0] c,
		input logic [DAC_BITS-1:0] s
	);
		logic signed [DAC_BITS+1:0] diff;
		logic [DAC_BITS+1:0]        sum;
		logic [DAC_BITS-1:0]        lo;
		logic [DAC_BITS-1:0]        hi;
		diff = $signed({1'b0, c, 1'b0}) - $signed({2'b00, s});
		sum  = {1'b0, c, 1'b0} + {2'b00, s};
		lo   = diff[DAC_BITS+1] ? '0 : diff[DAC_BITS:1];
		hi   = sum[DAC_BITS+1] ? DAC_MAX : sum[DAC_BITS:1];
		return {hi, lo};
	endfunction

	assign take = start && !active_q;

	// point count and edge/diagonal length for the current shape
	always_comb begin
		case (cmd_q)
			CMD_CIRCLE: last_idx = IDX_W'(CIRCLE_POINTS - 1);
			CMD_SQUARE: last_idx = IDX_W'(SHAPE_POINTS - 1);
			CMD_CROSS:  last_idx = IDX_W'(SHAPE_POINTS - 1);
			default:    last_idx = '0;
		endcase
		step_top = (cmd_q == CMD_SQUARE) ? STEP_W'(EDGE_POINTS - 1) : STEP_W'(DIAG_POINTS - 1);
		is_last  = (idx_q == last_idx);
		x_corner = corners(center_x, size);
		y_corner = corners(center_y, size);
	end

	// point counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cmd_q    <= CMD_POINT;
			idx_q    <= '0;
			step_q   <= '0;
			grp_q    <= '0;
		end else if (take) begin
			active_q <= 1'b1;
			cmd_q    <= cmd_t'(cmd);
			idx_q    <= '0;
			step_q   <= '0;
			grp_q    <= '0;
		end else if (active_q) begin
			if (is_last) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (step_q == step_top) begin
					step_q <= '0;
					grp_q  <= grp_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// command word and corners, held for the whole shape
	always_ff @(posedge clk) begin
		if (take) begin
			cx_q <= center_x;
			cy_q <= center_y;
			sz_q <= size;
			xl_q <= x_corner[DAC_BITS-1:0];
			xh_q <= x_corner[2*DAC_BITS-1:DAC_BITS];
			yl_q <= y_corner[DAC_BITS-1:0];
			yh_q <= y_corner[2*DAC_BITS-1:DAC_BITS];
		end
	end

	assign busy       = active_q;
	assign issue.valid = active_q;
	assign issue.cmd   = cmd_q;
	assign issue.idx   = idx_q;
	assign issue.step  = step_q;
	assign issue.grp   = grp_q;
	assign issue.last  = is_last;
	assign cx   = cx_q;
	assign cy   = cy_q;
	assign sz   = sz_q;
	assign x_lo = xl_q;
	assign x_hi = xh_q;
	assign y_lo = yl_q;
	assign y_hi = yh_q;

endmodule

`default_nettype wire

// File: hdl/lswg_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module lswg_axis import lswg_pkg::*; #(
	parameter int unsigned DAC_BITS = 12,
	parameter bit          IS_Y     = 1'b0
) (
	input  wire logic                clk,
	input  wire issue_t              issue,
	input  wire logic [DAC_BITS-1:0] center,
	input  wire logic [DAC_BITS-1:0] size,
	input  wire logic [DAC_BITS-1:0] lo,
	input  wire logic [DAC_BITS-1:0] hi,
	output logic [DAC_BITS-1:0]      point
);

	localparam int unsigned BW     = DAC_BITS + 19;   // signed numerator
	localparam int unsigned PW     = DAC_BITS + 1;    // signed multiplicand
	localparam int unsigned NW     = BW - 1;          // numerator magnitude
	localparam int unsigned MI_W   = DAC_BITS + 5;    // reciprocal multiply input
	localparam int unsigned MC_W   = DAC_BITS + 7;    // reciprocal constant
	localparam int unsigned KS     = DAC_BITS + 9;    // reciprocal scale
	localparam int unsigned QW     = DAC_BITS + 2;    // quotient before clamp
	localparam int unsigned CROSS_DEN = 2 * (DIAG_POINTS - 1);
	localparam int unsigned CROSS_MID = DIAG_POINTS - 1;

	localparam logic [MC_W-1:0] RECIP_6 =
		MC_W'(((64'd1 << KS) + 64'd5) / 64'd6);
	localparam logic [MC_W-1:0] RECIP_11 =
		MC_W'(((64'd1 << KS) + 64'd10) / 64'd11);
	localparam logic [DAC_BITS-1:0]         DAC_MAX = '1;
	localparam logic signed [TRIG_W-1:0]    W_MID   = TRIG_W'(CROSS_MID);

	// stage 1: numerator = base + p * w
	logic [DAC_BITS-1:0]       a_c, b_c;
	logic signed [TRIG_W-1:0]  step2;
	logic signed [BW-1:0]      base_d;
	logic signed [PW-1:0]      p_d;
	logic signed [TRIG_W-1:0]  w_d;
	div_mode_t                 mode_d;

	logic signed [BW-1:0]      base_s1;
	logic signed [PW-1:0]      p_s1;
	logic signed [TRIG_W-1:0]  w_s1;
	div_mode_t                 mode_s1;

	logic signed [BW-1:0]      base_s2;
	logic signed [BW-1:0]      prod_s2;
	div_mode_t                 mode_s2;

	logic signed [BW-1:0]      sum_d;
	logic [NW-1:0]             num_s3;
	logic                      neg_s3;
	div_mode_t                 mode_s3;

	logic [MI_W-1:0]           mul_in;
	logic [MC_W-1:0]           mul_k;
	logic [MI_W+MC_W-1:0]      recip_d;
	logic [QW-1:0]             q_d;
	logic [QW-1:0]             q_s4;
	logic                      neg_s4;

	logic [DAC_BITS-1:0]       point_s5;

	// edge endpoints: corner k and the next corner in drawing order
	always_comb begin
		if (IS_Y) begin
			a_c = issue.grp[1] ? hi : lo;
			b_c = (issue.grp == 2'd1 || issue.grp == 2'd2) ? hi : lo;
		end else begin
			a_c = (issue.grp == 2'd1 || issue.grp == 2'd2) ? hi : lo;
			b_c = (issue.grp == 2'd0 || issue.grp == 2'd1) ? hi : lo;
		end
		step2 = $signed({{(TRIG_W-STEP_W-1){1'b0}}, issue.step, 1'b0});
	end

	// operand select per shape
	always_comb begin
		case (issue.cmd)
			CMD_CIRCLE: begin
				base_d = $signed({2'b00, center, 1'b1, 16'h0000});
				p_d    = $signed({1'b0, size});
				w_d    = IS_Y ? sin_q16(issue.idx) : cos_q16(issue.idx);
				mode_d = DIV_SHIFT;
			end
			CMD_SQUARE: begin
				base_d = $signed(BW'(a_c) * BW'(EDGE_POINTS) + BW'(EDGE_POINTS / 2));
				p_d    = $signed({1'b0, b_c}) - $signed({1'b0, a_c});
				w_d    = $signed({{(TRIG_W-STEP_W){1'b0}}, issue.step});
				mode_d = DIV_SIX;
			end
			CMD_CROSS: begin
				base_d = $signed(BW'(center) * BW'(CROSS_DEN) + BW'(CROSS_MID));
				p_d    = $signed({1'b0, size});
				w_d    = (IS_Y && issue.grp[0]) ? (W_MID - step2) : (step2 - W_MID);
				mode_d = DIV_22;
			end
			default: begin
				base_d = $signed(BW'(center));
				p_d    = '0;
				w_d    = '0;
				mode_d = DIV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		base_s1 <= base_d;
		p_s1    <= p_d;
		w_s1    <= w_d;
		mode_s1 <= mode_d;
	end

	// stage 2: product
	always_ff @(posedge clk) begin
		prod_s2 <= p_s1 * w_s1;
		base_s2 <= base_s1;
		mode_s2 <= mode_s1;
	end

	// stage 3: full numerator with rounding half already folded in
	assign sum_d = base_s2 + prod_s2;

	always_ff @(posedge clk) begin
		neg_s3  <= sum_d[BW-1];
		num_s3  <= sum_d[NW-1:0];
		mode_s3 <= mode_s2;
	end

	// stage 4: scale down, reciprocal multiply for /6 and /22
	always_comb begin
		mul_in  = (mode_s3 == DIV_SIX) ? num_s3[MI_W-1:0] : num_s3[MI_W:1];
		mul_k   = (mode_s3 == DIV_SIX) ? RECIP_6 : RECIP_11;
		recip_d = mul_in * mul_k;
		case (mode_s3)
			DIV_SHIFT: q_d = QW'(num_s3[NW-1:CIRCLE_SHIFT]);
			DIV_SIX:   q_d = recip_d[KS+QW-1:KS];
			DIV_22:    q_d = recip_d[KS+QW-1:KS];
			default:   q_d = num_s3[QW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		q_s4   <= q_d;
		neg_s4 <= neg_s3;
	end

	// stage 5: clamp to the DAC range
	always_ff @(posedge clk) begin
		if (neg_s4) begin
			point_s5 <= '0;
		end else if (q_s4 > QW'(DAC_MAX)) begin
			point_s5 <= DAC_MAX;
		end else begin
			point_s5 <= q_s4[DAC_BITS-1:0];
		end
	end

	assign point = point_s5;

endmodule

`default_nettype wire

// File: hdl/laser_shape_waypoint_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// The first waypoint strobe rises after the edge that takes start.
// Throughput: one waypoint per cycle while busy is high; busy stays high until
// the point counter has issued 20 (circle), 24 (square, cross) or 1 (point)
// points; a new command is taken at the first edge after busy drops, while the
// 5-stage arithmetic pipe still drains.
// Results cannot be stalled. Reset clears the point counter and valid bits.
module laser_shape_waypoint_generator import lswg_pkg::*; #(
	parameter int unsigned DAC_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [DAC_BITS-1:0] center_x,
	input  wire logic [DAC_BITS-1:0] center_y,
	input  wire logic [1:0]          cmd,
	input  wire logic [DAC_BITS-1:0] size,
	output logic                     point_valid,
	output logic [DAC_BITS-1:0]      point_x,
	output logic [DAC_BITS-1:0]      point_y,
	output logic                     last_point
);

	issue_t              issue;
	logic [DAC_BITS-1:0] cx, cy, sz, x_lo, x_hi, y_lo, y_hi;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	lswg_seq #(.DAC_BITS(DAC_BITS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.center_x (center_x),
		.center_y (center_y),
		.size     (size),
		.busy     (busy),
		.issue    (issue),
		.cx       (cx),
		.cy       (cy),
		.sz       (sz),
		.x_lo     (x_lo),
		.x_hi     (x_hi),
		.y_lo     (y_lo),
		.y_hi     (y_hi)
	);

	lswg_axis #(.DAC_BITS(DAC_BITS), .IS_Y(1'b0)) u_axis_x (
		.clk    (clk),
		.issue  (issue),
		.center (cx),
		.size   (sz),
		.lo     (x_lo),
		.hi     (x_hi),
		.point  (point_x)
	);

	lswg_axis #(.DAC_BITS(DAC_BITS), .IS_Y(1'b1)) u_axis_y (
		.clk    (clk),
		.issue  (issue),
		.center (cy),
		.size   (sz),
		.lo     (y_lo),
		.hi     (y_hi),
		.point  (point_y)
	);

	// valid and last flags ride alongside the axis pipes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= issue.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= issue.last;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
		last_s5 <= last_s4;
	end

	assign point_valid = vld_s5;
	assign last_point  = vld_s5 && last_s5;

endmodule

`default_nettype wire

// File: hdl/lswg_check.sv
`timescale 1ns / 1ps
`default_nettype none

module lswg_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic point_valid,
	input wire logic last_point
);

	// a taken command raises busy in the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command taken but busy not raised");

	// every waypoint comes from a point issued while busy was high
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> $past(busy, 5))
		else $error("waypoint without a command in flight");

	// the final issued point shows up as the marked last waypoint
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> ##4 (point_valid && last_point))
		else $error("last waypoint missing after shape ended");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_point |-> point_valid)
		else $error("last_point without strobe");

endmodule

bind laser_shape_waypoint_generator lswg_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.point_valid (point_valid),
	.last_point  (last_point)
);

`default_nettype wire

// File: sim/waypoint_checker.sv
`timescale 1ns / 1ps

// Watches the command and waypoint channels, works out the waypoints each
// accepted command should trace, and compares them in order with what comes out.
module waypoint_checker import lswg_pkg::*; #(
	parameter int unsigned DAC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [DAC_BITS-1:0] center_x,
	input  logic [DAC_BITS-1:0] center_y,
	input  logic [1:0]          cmd,
	input  logic [DAC_BITS-1:0] size,
	input  logic                point_valid,
	input  logic [DAC_BITS-1:0] point_x,
	input  logic [DAC_BITS-1:0] point_y,
	input  logic                last_point,
	output int unsigned         mismatches,
	output int unsigned         pending
);

	localparam longint DAC_TOP    = (64'sd1 <<< DAC_BITS) - 64'sd1;
	localparam longint TRIG_ONE   = 131072;
	localparam int     RING_STEPS = 20;
	localparam int     EDGE_STEPS = 6;
	localparam int     DIAG_STEPS = 12;

	typedef struct packed {
		logic [DAC_BITS-1:0] x;
		logic [DAC_BITS-1:0] y;
		logic                last;
	} waypoint_t;

	waypoint_t   expected_points[$];
	int unsigned fail_count = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// cos(2*pi*k/20) in Q1.16, exact on the axes
	function automatic longint unit_cos(input int k);
		case (k)
			0:       return 65536;
			1, 19:   return 62328;
			2, 18:   return 53020;
			3, 17:   return 38521;
			4, 16:   return 20252;
			6, 14:   return -20252;
			7, 13:   return -38521;
			8, 12:   return -53020;
			9, 11:   return -62328;
			10:      return -65536;
			default: return 0;
		endcase
	endfunction

	// num/den rounded half up, then held to the DAC range
	function automatic logic [DAC_BITS-1:0] round_clamp(input longint num, input longint den);
		longint t;
		t = num + den / 2;
		if (t < 0)
			return '0;
		t = t / den;
		if (t > DAC_TOP)
			return DAC_TOP[DAC_BITS-1:0];
		return t[DAC_BITS-1:0];
	endfunction

	// square corner along one axis: floor of c -/+ size/2, clamped
	function automatic void square_span(input longint c, input longint sz,
			output longint lo, output longint hi);
		longint l;
		longint h;
		l = 2 * c - sz;
		h = (2 * c + sz) / 2;
		lo = (l < 0) ? 0 : l / 2;
		hi = (h > DAC_TOP) ? DAC_TOP : h;
	endfunction

	// queue every waypoint one shape command traces
	task automatic trace_shape(input cmd_t shape, input longint cx, input longint cy,
			input longint sz);
		longint    xs[4];
		longint    ys[4];
		longint    sx;
		longint    sy;
		waypoint_t w;
		int        idx;
		idx = 0;
		case (shape)
			CMD_CIRCLE: begin
				for (int i = 0; i < RING_STEPS; i++) begin
					w.x = round_clamp(cx * TRIG_ONE + sz * unit_cos(i), TRIG_ONE);
					w.y = round_clamp(cy * TRIG_ONE + sz * unit_cos((i + 15) % RING_STEPS),
						TRIG_ONE);
					w.last = (i == RING_STEPS - 1);
					expected_points.push_back(w);
				end
			end
			CMD_SQUARE: begin
				square_span(cx, sz, xs[0], xs[1]);
				square_span(cy, sz, ys[0], ys[2]);
				xs[2] = xs[1];
				xs[3] = xs[0];
				ys[1] = ys[0];
				ys[3] = ys[2];
				for (int k = 0; k < 4; k++) begin
					for (int s = 0; s < EDGE_STEPS; s++) begin
						w.x = round_clamp(xs[k] * (EDGE_STEPS - s) + xs[(k + 1) % 4] * s,
							EDGE_STEPS);
						w.y = round_clamp(ys[k] * (EDGE_STEPS - s) + ys[(k + 1) % 4] * s,
							EDGE_STEPS);
						w.last = (idx == 4 * EDGE_STEPS - 1);
						expected_points.push_back(w);
						idx++;
					end
				end
			end
			CMD_CROSS: begin
				// both diagonals in units of 1/22, rising then falling in y
				for (int d = 0; d < 2; d++) begin
					for (int s = 0; s < DIAG_STEPS; s++) begin
						sx = 22 * cx - 11 * sz + 2 * sz * s;
						sy = (d == 0) ? 22 * cy - 11 * sz + 2 * sz * s
						              : 22 * cy + 11 * sz - 2 * sz * s;
						w.x = round_clamp(sx, 22);
						w.y = round_clamp(sy, 22);
						w.last = (idx == 2 * DIAG_STEPS - 1);
						expected_points.push_back(w);
						idx++;
					end
				end
			end
			default: begin
				w.x = cx[DAC_BITS-1:0];
				w.y = cy[DAC_BITS-1:0];
				w.last = 1'b1;
				expected_points.push_back(w);
			end
		endcase
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		waypoint_t w;
		if (arst_n) begin
			// compare a waypoint word with the oldest one owed
			if (point_valid) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected waypoint: actual x %0d y %0d last %0d",
						$time, point_x, point_y, last_point);
					fail_count++;
				end else begin
					w = expected_points.pop_front();
					check_field("point_x", w.x, point_x);
					check_field("point_y", w.y, point_y);
					check_field("last_point", w.last, last_point);
				end
			end
			// command word taken this edge
			if (start && !busy)
				trace_shape(cmd_t'(cmd), center_x, center_y, size);
		end
		mismatches <= fail_count;
		pending <= expected_points.size();
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lswg_pkg::*;

	localparam int unsigned DAC_BITS      = 12;
	localparam int unsigned RANDOM_SHAPES = 450;
	localparam int unsigned DRAIN_CYCLES  = 16;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam logic [11:0] TOP_CODE      = 12'd4095;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [DAC_BITS-1:0] center_x = '0;
	logic [DAC_BITS-1:0] center_y = '0;
	logic [1:0]          cmd = CMD_POINT;
	logic [DAC_BITS-1:0] size = '0;
	logic                point_valid;
	logic [DAC_BITS-1:0] point_x;
	logic [DAC_BITS-1:0] point_y;
	logic                last_point;
	int unsigned         mismatches;
	int unsigned         pending;
	int unsigned         cycles = 0;
	bit                  burst = 1'b0;

	laser_shape_waypoint_generator #(.DAC_BITS(DAC_BITS)) dut (.*);
	waypoint_checker #(.DAC_BITS(DAC_BITS)) chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// idle cycles before the next command: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// coordinate that lands near the DAC rails a fair share of the time
	function automatic logic [11:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return 12'($urandom_range(0, 31));
			1:       return 12'($urandom_range(4064, 4095));
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// drive one command word and hold it until it is taken
	task automatic send_shape(input cmd_t shape, input logic [11:0] cx, input logic [11:0] cy,
			input logic [11:0] sz);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
			center_x = 12'($urandom_range(0, 4095));
			center_y = 12'($urandom_range(0, 4095));
			cmd = 2'($urandom_range(0, 3));
			size = 12'($urandom_range(0, 4095));
		end
		@(negedge clk);
		center_x = cx;
		center_y = cy;
		cmd = shape;
		size = sz;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		cmd_t        shape;
		logic [11:0] sz;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: rails, zero size, odd sizes, clamping on both sides
		send_shape(CMD_POINT, 12'd0, 12'd0, 12'd0);
		send_shape(CMD_POINT, TOP_CODE, TOP_CODE, TOP_CODE);
		send_shape(CMD_POINT, 12'd2048, 12'd1, 12'd77);
		send_shape(CMD_CIRCLE, 12'd2048, 12'd2048, 12'd0);
		send_shape(CMD_CIRCLE, 12'd2048, 12'd2048, TOP_CODE);
		send_shape(CMD_CIRCLE, 12'd0, 12'd0, TOP_CODE);
		send_shape(CMD_CIRCLE, TOP_CODE, TOP_CODE, TOP_CODE);
		send_shape(CMD_CIRCLE, 12'd0, TOP_CODE, 12'd1);
		send_shape(CMD_SQUARE, 12'd2048, 12'd2048, 12'd0);
		send_shape(CMD_SQUARE, 12'd2048, 12'd2047, TOP_CODE);
		send_shape(CMD_SQUARE, 12'd0, 12'd0, TOP_CODE);
		send_shape(CMD_SQUARE, TOP_CODE, TOP_CODE, TOP_CODE);
		send_shape(CMD_SQUARE, 12'd100, 12'd3, 12'd7);
		send_shape(CMD_SQUARE, 12'd0, 12'd2, 12'd5);
		send_shape(CMD_CROSS, 12'd1000, 12'd1000, 12'd0);
		send_shape(CMD_CROSS, 12'd0, 12'd0, TOP_CODE);
		send_shape(CMD_CROSS, TOP_CODE, TOP_CODE, TOP_CODE);
		send_shape(CMD_CROSS, 12'd2048, 12'd2048, 12'd11);
		send_shape(CMD_CROSS, 12'd0, TOP_CODE, 12'd1);
		send_shape(CMD_CROSS, 12'd5, 12'd4090, 12'd13);

		// random commands, with stretches sent back to back
		for (int n = 0; n < RANDOM_SHAPES; n++) begin
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
			shape = cmd_t'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0:       sz = 12'($urandom_range(0, 15));
				1:       sz = 12'($urandom_range(4000, 4095));
				default: sz = 12'($urandom_range(0, 4095));
			endcase
			send_shape(shape, pick_coord(), pick_coord(), sz);
		end

		// drop start so nothing more is taken, then let the pipe drain
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
